[design/llcp_pkg.sv]
// Shared types and constants for the line-line closest points core.
// Used by every module of the datapath; depends on nothing else.
package llcp_pkg;

    localparam int DIR_FRAC = 30;
    // Numerator magnitude bits fed to the divider (one quotient bit per stage).
    localparam int NMAG = 101;
    // Divisor width (Q.30 determinant).
    localparam int DVW = 40;
    // Width of the line parameters sa and sb.
    localparam int SAW = 72;
    // Sum of squares width and square root working width.
    localparam int SQW = 66;
    localparam int RW = 67;
    localparam int ROOT_STEPS = 33;

    localparam logic [30:0] THR_RESET = 31'd1073742;

    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        vec3_t a;
        vec3_t b;
        vec3_t pa;
        vec3_t pb;
    } geom_t;

    typedef struct packed {
        geom_t           g;
        logic            par;
        logic            sign1;
        logic            sign2;
        logic [SAW-1:0]  sa_par;
    } div_side_t;

    typedef struct packed {
        logic [NMAG-1:0] mag1;
        logic [NMAG-1:0] mag2;
        logic [DVW-1:0]  dvs;
        div_side_t       side;
    } div_in_t;

    typedef struct packed {
        logic [NMAG-1:0] q1;
        logic [NMAG-1:0] q2;
        div_side_t       side;
    } div_out_t;

    typedef struct packed {
        vec3_t near_a;
        vec3_t near_b;
        logic  par;
        logic  big;
    } root_side_t;

    typedef struct packed {
        logic [SQW-1:0] sum;
        root_side_t     side;
    } root_in_t;

    typedef struct packed {
        logic [32:0]    root;
        logic [SQW-1:0] sum;
        root_side_t     side;
    } root_out_t;

endpackage

[design/llcp_front.sv]
// Front end: dot products, alpha, determinant, parallel test and numerators.
// Seven register stages; depends on llcp_pkg.
module llcp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  llcp_pkg::geom_t  in_geom,
    input  logic [30:0]      thr,
    output logic             out_vld,
    output llcp_pkg::div_in_t out_data
);
    import llcp_pkg::*;

    logic [6:0] vld_reg;

    geom_t g1_reg, g2_reg, g3_reg, g4_reg, g5_reg, g6_reg;

    logic signed [32:0] df_next [3];
    logic signed [63:0] pab_next [3], pab_reg [3];
    logic signed [64:0] pda_next [3], pda_reg [3];
    logic signed [64:0] pdb_next [3], pdb_reg [3];

    logic signed [65:0] dot_next, dot_reg;
    logic signed [66:0] b1_next, b1_reg, b1_4_reg, b1_5_reg;
    logic signed [66:0] bb_next, bb_reg, bb_4_reg, bb_5_reg;

    logic signed [65:0] dot_rnd;
    logic signed [36:0] alpha_next, alpha_reg;

    logic signed [73:0]  alsq_next, alsq_reg;
    logic signed [71:0]  p1l_next, p1l_reg, p2l_next, p2l_reg;
    logic signed [69:0]  p1h_next, p1h_reg, p2h_next, p2h_reg;
    logic signed [37:0]  aabs;
    logic signed [37:0]  d2s;
    logic [37:0]         det2_next, det2_reg;

    logic signed [74:0]  det60s;
    logic [74:0]         det60;
    logic [DVW-1:0]      dvs_next, dvs_reg;
    logic                par_next, par_reg;
    logic signed [104:0] n1_next, n1_reg, n2_next, n2_reg;
    logic [104:0]        m1, m2;
    logic signed [66:0]  b1r;
    logic signed [37:0]  sp_next, sp_reg;
    div_in_t             out_next, out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            df_next[k]  = $signed({g1_reg.pa[k][31], g1_reg.pa[k]})
                        - $signed({g1_reg.pb[k][31], g1_reg.pb[k]});
            pab_next[k] = $signed(g1_reg.a[k]) * $signed(g1_reg.b[k]);
            pda_next[k] = df_next[k] * $signed(g1_reg.a[k]);
            pdb_next[k] = df_next[k] * $signed(g1_reg.b[k]);
        end
    end

    always_comb
    begin
        dot_next = 66'(pab_reg[0]) + 66'(pab_reg[1]) + 66'(pab_reg[2]);
        b1_next  = 67'(pda_reg[0]) + 67'(pda_reg[1]) + 67'(pda_reg[2]);
        bb_next  = -(67'(pdb_reg[0]) + 67'(pdb_reg[1]) + 67'(pdb_reg[2]));
    end

    // Alpha is minus the dot product rounded half up to Q.30.
    always_comb
    begin
        dot_rnd    = dot_reg + 66'sd536870912;
        alpha_next = -$signed({dot_rnd[65], dot_rnd[65:30]});
    end

    // The wide numerator products are split at bit 34 of the second operand
    // and recombined in the next stage.
    always_comb
    begin
        alsq_next = 74'(alpha_reg) * 74'(alpha_reg);
        p1l_next  = 72'(alpha_reg) * 72'($signed({1'b0, bb_4_reg[33:0]}));
        p1h_next  = 70'(alpha_reg) * 70'($signed(bb_4_reg[66:34]));
        p2l_next  = 72'(alpha_reg) * 72'($signed({1'b0, b1_4_reg[33:0]}));
        p2h_next  = 70'(alpha_reg) * 70'($signed(b1_4_reg[66:34]));
        aabs      = alpha_reg[36] ? -38'(alpha_reg) : 38'(alpha_reg);
        d2s       = 38'sd1073741824 - aabs;
        det2_next = d2s[37] ? 38'(-d2s) : 38'(d2s);
    end

    always_comb
    begin
        det60s   = (75'sd1 <<< 60) - 75'(alsq_reg);
        det60    = det60s[74] ? 75'(-det60s) : 75'(det60s);
        dvs_next = det60[DVW+29:30];
        // A zero determinant is handled by the parallel branch.
        par_next = (det2_reg < {7'd0, thr}) || (dvs_next == '0);
        n1_next  = (105'(p1h_reg) <<< 34) + 105'(p1l_reg) - (105'(b1_5_reg) <<< 30);
        n2_next  = (105'(p2h_reg) <<< 34) + 105'(p2l_reg) - (105'(bb_5_reg) <<< 30);
        b1r      = b1_5_reg + 67'sd536870912;
        sp_next  = -$signed({b1r[66], b1r[66:30]});
    end

    always_comb
    begin
        m1 = n1_reg[104] ? 105'(-n1_reg) : 105'(n1_reg);
        m2 = n2_reg[104] ? 105'(-n2_reg) : 105'(n2_reg);

        out_next.mag1        = m1[NMAG-1:0];
        out_next.mag2        = m2[NMAG-1:0];
        out_next.dvs         = dvs_reg;
        out_next.side.g      = g6_reg;
        out_next.side.par    = par_reg;
        out_next.side.sign1  = n1_reg[104];
        out_next.side.sign2  = n2_reg[104];
        out_next.side.sa_par = SAW'(sp_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_reg <= in_geom;
            g2_reg <= g1_reg;
            g3_reg <= g2_reg;
            g4_reg <= g3_reg;
            g5_reg <= g4_reg;
            g6_reg <= g5_reg;
            for (int k = 0; k < 3; k++)
            begin
                pab_reg[k] <= pab_next[k];
                pda_reg[k] <= pda_next[k];
                pdb_reg[k] <= pdb_next[k];
            end
            dot_reg   <= dot_next;
            b1_reg    <= b1_next;
            bb_reg    <= bb_next;
            alpha_reg <= alpha_next;
            b1_4_reg  <= b1_reg;
            bb_4_reg  <= bb_reg;
            alsq_reg  <= alsq_next;
            p1l_reg   <= p1l_next;
            p1h_reg   <= p1h_next;
            p2l_reg   <= p2l_next;
            p2h_reg   <= p2h_next;
            det2_reg  <= det2_next;
            b1_5_reg  <= b1_4_reg;
            bb_5_reg  <= bb_4_reg;
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            dvs_reg   <= dvs_next;
            par_reg   <= par_next;
            sp_reg    <= sp_next;
            out_reg   <= out_next;
        end
    end

    assign out_vld  = vld_reg[6];
    assign out_data = out_reg;

endmodule

[design/llcp_div.sv]
// Pipelined restoring divider for both line parameters, one quotient bit per stage.
// Side information travels alongside; depends on llcp_pkg.
module llcp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  llcp_pkg::div_in_t  din,
    output logic               out_vld,
    output llcp_pkg::div_out_t dout
);
    import llcp_pkg::*;

    typedef struct packed {
        logic [DVW-1:0]  rem;
        logic [NMAG-1:0] num;
    } dstep_t;

    function automatic dstep_t div_step(input logic [DVW-1:0] rem,
                                        input logic [NMAG-1:0] num,
                                        input logic [DVW-1:0] d);
        dstep_t     r;
        logic [DVW:0] sh;
        logic       q;
        sh = {rem, num[NMAG-1]};
        if (sh >= {1'b0, d})
        begin
            r.rem = DVW'(sh - {1'b0, d});
            q     = 1'b1;
        end
        else
        begin
            r.rem = sh[DVW-1:0];
            q     = 1'b0;
        end
        r.num = {num[NMAG-2:0], q};
        return r;
    endfunction

    logic [NMAG:0]   vld_reg;
    logic [DVW-1:0]  rem1_reg [NMAG+1];
    logic [DVW-1:0]  rem2_reg [NMAG+1];
    logic [NMAG-1:0] num1_reg [NMAG+1];
    logic [NMAG-1:0] num2_reg [NMAG+1];
    logic [DVW-1:0]  dvs_reg  [NMAG+1];
    div_side_t       side_reg [NMAG+1];
    dstep_t          s1_next  [NMAG];
    dstep_t          s2_next  [NMAG];

    always_comb
    begin
        for (int s = 0; s < NMAG; s++)
        begin
            s1_next[s] = div_step(rem1_reg[s], num1_reg[s], dvs_reg[s]);
            s2_next[s] = div_step(rem2_reg[s], num2_reg[s], dvs_reg[s]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NMAG-1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem1_reg[0] <= '0;
            rem2_reg[0] <= '0;
            num1_reg[0] <= din.mag1;
            num2_reg[0] <= din.mag2;
            dvs_reg[0]  <= din.dvs;
            side_reg[0] <= din.side;
            for (int s = 1; s <= NMAG; s++)
            begin
                rem1_reg[s] <= s1_next[s-1].rem;
                num1_reg[s] <= s1_next[s-1].num;
                rem2_reg[s] <= s2_next[s-1].rem;
                num2_reg[s] <= s2_next[s-1].num;
                dvs_reg[s]  <= dvs_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_vld   = vld_reg[NMAG];
    assign dout.q1   = num1_reg[NMAG];
    assign dout.q2   = num2_reg[NMAG];
    assign dout.side = side_reg[NMAG];

endmodule

[design/llcp_back.sv]
// Back end: line parameters, closest points, saturation and sum of squares.
// Seven register stages; depends on llcp_pkg.
module llcp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  llcp_pkg::div_out_t  din,
    output logic                out_vld,
    output llcp_pkg::root_in_t  dout
);
    import llcp_pkg::*;

    function automatic logic [31:0] sat32(input logic signed [75:0] v);
        logic [31:0] r;
        if (v > 76'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -76'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [6:0] vld_reg;

    geom_t g1_reg, g2_reg, g3_reg;
    logic  par1_reg, par2_reg, par3_reg, par4_reg, par5_reg, par6_reg, par7_reg;

    logic signed [101:0] q1s, q2s, q1r, q2r;
    logic signed [SAW-1:0] sa_next, sb_next, sa_reg, sb_reg;

    logic signed [68:0]  pral_next [3], pral_reg [3];
    logic signed [67:0]  prah_next [3], prah_reg [3];
    logic signed [68:0]  prbl_next [3], prbl_reg [3];
    logic signed [67:0]  prbh_next [3], prbh_reg [3];
    logic signed [103:0] pra_next [3], pra_reg [3];
    logic signed [103:0] prb_next [3], prb_reg [3];

    logic signed [103:0] ra [3], rb [3];
    logic signed [75:0]  na_next [3], na_reg [3];
    logic signed [75:0]  nb_next [3], nb_reg [3];

    logic signed [76:0]  w [3];
    logic [76:0]         wm [3];
    logic [31:0]         wm_next [3], wm_reg [3];
    logic                big_next, big_reg, big5_reg, big6_reg;
    vec3_t               near_a_next, near_b_next;
    vec3_t               near_a_reg, near_b_reg, near_a5_reg, near_b5_reg;
    vec3_t               near_a6_reg, near_b6_reg;

    logic [63:0]         sqr_reg [3];
    logic [SQW-1:0]      sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    // Quotients are rounded half up from Q.30 to the point format.
    always_comb
    begin
        q1s     = din.side.sign1 ? -102'({1'b0, din.q1}) : 102'({1'b0, din.q1});
        q2s     = din.side.sign2 ? -102'({1'b0, din.q2}) : 102'({1'b0, din.q2});
        q1r     = q1s + 102'sd536870912;
        q2r     = q2s + 102'sd536870912;
        sa_next = din.side.par ? $signed(din.side.sa_par) : $signed(q1r[101:30]);
        sb_next = din.side.par ? '0 : $signed(q2r[101:30]);
    end

    // Each line parameter is split into two 36-bit halves for the products.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pral_next[k] = 69'($signed({1'b0, sa_reg[35:0]})) * 69'($signed(g1_reg.a[k]));
            prah_next[k] = 68'($signed(sa_reg[71:36])) * 68'($signed(g1_reg.a[k]));
            prbl_next[k] = 69'($signed({1'b0, sb_reg[35:0]})) * 69'($signed(g1_reg.b[k]));
            prbh_next[k] = 68'($signed(sb_reg[71:36])) * 68'($signed(g1_reg.b[k]));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pra_next[k] = (104'(prah_reg[k]) <<< 36) + 104'(pral_reg[k]);
            prb_next[k] = (104'(prbh_reg[k]) <<< 36) + 104'(prbl_reg[k]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ra[k]      = pra_reg[k] + 104'sd536870912;
            rb[k]      = prb_reg[k] + 104'sd536870912;
            na_next[k] = 76'($signed(g3_reg.pa[k])) + 76'($signed(ra[k][103:30]));
            nb_next[k] = 76'($signed(g3_reg.pb[k])) + 76'($signed(rb[k][103:30]));
        end
    end

    always_comb
    begin
        big_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            w[k]           = 77'(na_reg[k]) - 77'(nb_reg[k]);
            wm[k]          = w[k][76] ? 77'(-w[k]) : 77'(w[k]);
            wm_next[k]     = wm[k][31:0];
            near_a_next[k] = sat32(na_reg[k]);
            near_b_next[k] = sat32(nb_reg[k]);
            if (wm[k][76:32] != '0)
            begin
                big_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg   <= sa_next;
            sb_reg   <= sb_next;
            g1_reg   <= din.side.g;
            par1_reg <= din.side.par;
            g2_reg   <= g1_reg;
            par2_reg <= par1_reg;
            g3_reg   <= g2_reg;
            par3_reg <= par2_reg;
            par4_reg <= par3_reg;
            par5_reg <= par4_reg;
            par6_reg <= par5_reg;
            par7_reg <= par6_reg;
            for (int k = 0; k < 3; k++)
            begin
                pral_reg[k] <= pral_next[k];
                prah_reg[k] <= prah_next[k];
                prbl_reg[k] <= prbl_next[k];
                prbh_reg[k] <= prbh_next[k];
                pra_reg[k]  <= pra_next[k];
                prb_reg[k]  <= prb_next[k];
                na_reg[k]   <= na_next[k];
                nb_reg[k]   <= nb_next[k];
                wm_reg[k]   <= wm_next[k];
                sqr_reg[k]  <= 64'(wm_reg[k]) * 64'(wm_reg[k]);
            end
            big_reg     <= big_next;
            near_a_reg  <= near_a_next;
            near_b_reg  <= near_b_next;
            big5_reg    <= big_reg;
            near_a5_reg <= near_a_reg;
            near_b5_reg <= near_b_reg;
            sum_reg     <= SQW'(sqr_reg[0]) + SQW'(sqr_reg[1]) + SQW'(sqr_reg[2]);
            big6_reg    <= big5_reg;
            near_a6_reg <= near_a5_reg;
            near_b6_reg <= near_b5_reg;
        end
    end

    assign out_vld            = vld_reg[6];
    assign dout.sum           = sum_reg;
    assign dout.side.near_a   = near_a6_reg;
    assign dout.side.near_b   = near_b6_reg;
    assign dout.side.par      = par7_reg;
    assign dout.side.big      = big6_reg;

endmodule

[design/llcp_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
// Side information travels alongside; depends on llcp_pkg.
module llcp_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  llcp_pkg::root_in_t  din,
    output logic                out_vld,
    output llcp_pkg::root_out_t dout
);
    import llcp_pkg::*;

    logic [ROOT_STEPS:0] vld_reg;
    logic [RW-1:0]       num_reg  [ROOT_STEPS+1];
    logic [RW-1:0]       res_reg  [ROOT_STEPS+1];
    logic [SQW-1:0]      sum_reg  [ROOT_STEPS+1];
    root_side_t          side_reg [ROOT_STEPS+1];
    logic [RW-1:0]       num_next [ROOT_STEPS];
    logic [RW-1:0]       res_next [ROOT_STEPS];
    logic [RW-1:0]       bitv     [ROOT_STEPS];
    logic [RW-1:0]       trial    [ROOT_STEPS];

    // Stage s tests the root bit of weight 2^(ROOT_STEPS-1-s).
    always_comb
    begin
        for (int s = 0; s < ROOT_STEPS; s++)
        begin
            bitv[s]  = RW'(1) << (2 * (ROOT_STEPS - 1 - s));
            trial[s] = res_reg[s] + bitv[s];
            if (num_reg[s] >= trial[s])
            begin
                num_next[s] = num_reg[s] - trial[s];
                res_next[s] = (res_reg[s] >> 1) + bitv[s];
            end
            else
            begin
                num_next[s] = num_reg[s];
                res_next[s] = res_reg[s] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ROOT_STEPS-1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0]  <= RW'(din.sum);
            res_reg[0]  <= '0;
            sum_reg[0]  <= din.sum;
            side_reg[0] <= din.side;
            for (int s = 1; s <= ROOT_STEPS; s++)
            begin
                num_reg[s]  <= num_next[s-1];
                res_reg[s]  <= res_next[s-1];
                sum_reg[s]  <= sum_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_vld   = vld_reg[ROOT_STEPS];
    assign dout.root = res_reg[ROOT_STEPS][32:0];
    assign dout.sum  = sum_reg[ROOT_STEPS];
    assign dout.side = side_reg[ROOT_STEPS];

endmodule

[design/line_line_closest_points_core.sv]
// Closest points between two 3D lines: top level with the output register.
// Instantiates llcp_front, llcp_div, llcp_back and llcp_sqrt; depends on llcp_pkg.
//
// The core takes one line pair per cycle while in_stall is low and returns
// one result word per pair, in order, after 7 front-end stages, 102 divider
// stages (one quotient bit each after the first), 7 back-end stages, 34 square
// root stages and the output register. The pipeline moves as a whole; while a
// result sits in the output register and out_stall is high, in_stall is high and
// nothing advances. The parallel threshold may be rewritten only while the core is
// empty; cfg_ready is always high.
module line_line_closest_points_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] dir_a_x,
    input  logic signed [31:0] dir_a_y,
    input  logic signed [31:0] dir_a_z,
    input  logic signed [31:0] dir_b_x,
    input  logic signed [31:0] dir_b_y,
    input  logic signed [31:0] dir_b_z,
    input  logic signed [31:0] point_a_x,
    input  logic signed [31:0] point_a_y,
    input  logic signed [31:0] point_a_z,
    input  logic signed [31:0] point_b_x,
    input  logic signed [31:0] point_b_y,
    input  logic signed [31:0] point_b_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [62:0]        sq_distance,
    output logic [31:0]        distance,
    output logic               is_parallel,
    output logic signed [31:0] near_a_x,
    output logic signed [31:0] near_a_y,
    output logic signed [31:0] near_a_z,
    output logic signed [31:0] near_b_x,
    output logic signed [31:0] near_b_y,
    output logic signed [31:0] near_b_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        parallel_threshold
);
    import llcp_pkg::*;

    logic        en;
    logic [30:0] thr_reg;
    geom_t       in_geom;
    logic        f_vld, d_vld, b_vld, r_vld;
    div_in_t     f_data;
    div_out_t    d_data;
    root_in_t    b_data;
    root_out_t   r_data;

    logic        out_vld_reg;
    logic [62:0] sq_reg, sq_next;
    logic [31:0] dist_reg, dist_next;
    logic        par_reg;
    vec3_t       near_a_reg, near_b_reg;

    assign en        = !(out_vld_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    assign in_geom.a  = {dir_a_z, dir_a_y, dir_a_x};
    assign in_geom.b  = {dir_b_z, dir_b_y, dir_b_x};
    assign in_geom.pa = {point_a_z, point_a_y, point_a_x};
    assign in_geom.pb = {point_b_z, point_b_y, point_b_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= parallel_threshold;
        end
    end

    llcp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .in_geom  (in_geom),
        .thr      (thr_reg),
        .out_vld  (f_vld),
        .out_data (f_data)
    );

    llcp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (f_vld),
        .din     (f_data),
        .out_vld (d_vld),
        .dout    (d_data)
    );

    llcp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (d_vld),
        .din     (d_data),
        .out_vld (b_vld),
        .dout    (b_data)
    );

    llcp_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (b_vld),
        .din     (b_data),
        .out_vld (r_vld),
        .dout    (r_data)
    );

    // A component difference of 2^32 or more saturates both distance outputs.
    always_comb
    begin
        if (r_data.side.big || (r_data.sum[SQW-1:63] != '0))
        begin
            sq_next = 63'h7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            sq_next = r_data.sum[62:0];
        end
        if (r_data.side.big || r_data.root[32])
        begin
            dist_next = 32'hFFFF_FFFF;
        end
        else
        begin
            dist_next = r_data.root[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= r_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg     <= sq_next;
            dist_reg   <= dist_next;
            par_reg    <= r_data.side.par;
            near_a_reg <= r_data.side.near_a;
            near_b_reg <= r_data.side.near_b;
        end
    end

    assign out_valid   = out_vld_reg;
    assign sq_distance = sq_reg;
    assign distance    = dist_reg;
    assign is_parallel = par_reg;
    assign near_a_x    = near_a_reg[0];
    assign near_a_y    = near_a_reg[1];
    assign near_a_z    = near_a_reg[2];
    assign near_b_x    = near_b_reg[0];
    assign near_b_y    = near_b_reg[1];
    assign near_b_z    = near_b_reg[2];

endmodule
